// File: design/gpwd_pkg.sv
// shared constants for the guest-physical window decoder
// opcodes, status and target codes, register indexes and reset values
// no dependencies
package gpwd_pkg;

    localparam int WINDOWS = 16;
    localparam int IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int CNT_W = $clog2(WINDOWS + 1);
    localparam int ADDR_W = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_RELOCATE = 2'd1;
    localparam logic [1:0] OP_LOOKUP   = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_OVERLAP  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_MISS     = 3'd6;

    localparam logic [2:0] TG_NONE   = 3'd0;
    localparam logic [2:0] TG_IOAPIC = 3'd1;
    localparam logic [2:0] TG_HPET   = 3'd2;
    localparam logic [2:0] TG_LAPIC  = 3'd3;
    localparam logic [2:0] TG_TABLE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_IOAPIC_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IOAPIC_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HPET_BASE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HPET_SIZE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAPIC_BASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAPIC_SIZE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAPIC_ENABLE = 3'd6;

    localparam logic [ADDR_W-1:0] IOAPIC_BASE_RST = 64'h0000_0000_FEC0_0000;
    localparam logic [ADDR_W-1:0] IOAPIC_SIZE_RST = 64'd4096;
    localparam logic [ADDR_W-1:0] HPET_BASE_RST   = 64'h0000_0000_FED0_0000;
    localparam logic [ADDR_W-1:0] HPET_SIZE_RST   = 64'd1024;
    localparam logic [ADDR_W-1:0] LAPIC_BASE_RST  = 64'h0000_0000_FEE0_0000;
    localparam logic [ADDR_W-1:0] LAPIC_SIZE_RST  = 64'd4096;

endpackage

// File: design/gpwd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module gpwd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/guest_physical_window_decoder_top.sv
// guest-physical window decoder: fixed device windows plus a table of windows
// kept in two rams (start, end); uses gpwd_pkg and gpwd_ram
//
// one command at a time; busy is high from the accepting edge until the result beat,
// and the next command can be taken at the edge that takes the result.
// a fixed-window hit, a rejected register or an unknown opcode is answered from the check
// state; other commands scan the table slots in order, and a relocate hit passes through
// a relocate state that writes the moved window or reports an overflow.
// reset clears the window count and loads the fixed-window registers; table contents
// are undefined until written, no clearing pass. the result strobe cannot be stalled.
module guest_physical_window_decoder_top
    import gpwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           opcode,
    input  logic [ADDR_W-1:0]    address,
    input  logic [ADDR_W-1:0]    length,
    input  logic [ADDR_W-1:0]    new_start,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output logic                 done,
    output logic [2:0]           status,
    output logic [2:0]           target,
    output logic [3:0]           slot_index,
    output logic [ADDR_W-1:0]    offset
);

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SCAN, S_RELOC} state_t;

    state_t            state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] arg_reg, arg_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]  ev_idx_reg, ev_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg, done_next;
    logic [2:0]        status_reg, status_next;
    logic [2:0]        tgt_reg, tgt_next;
    logic [3:0]        slot_reg, slot_next;
    logic [ADDR_W-1:0] offset_reg, offset_next;

    logic [ADDR_W-1:0] ioapic_base_reg, ioapic_len_reg;
    logic [ADDR_W-1:0] hpet_base_reg, hpet_len_reg;
    logic [ADDR_W-1:0] lapic_base_reg, lapic_len_reg;
    logic              lapic_en_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ADDR_W-1:0] wr_start, wr_end;
    logic [ADDR_W-1:0] start_rd, end_rd;

    logic [ADDR_W:0]   reg_sum, rel_sum;
    logic [ADDR_W-1:0] io_off, hpet_off, lapic_off;
    logic              io_hit, hpet_hit, lapic_hit;
    logic              scan_hit;

    gpwd_ram #(.WIDTH(ADDR_W), .DEPTH(WINDOWS)) u_start_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_start),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (start_rd)
    );

    gpwd_ram #(.WIDTH(ADDR_W), .DEPTH(WINDOWS)) u_end_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_end),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (end_rd)
    );

    assign reg_sum   = {1'b0, base_reg} + {1'b0, arg_reg};
    assign rel_sum   = {1'b0, arg_reg} + {1'b0, len_reg};
    assign io_off    = base_reg - ioapic_base_reg;
    assign hpet_off  = base_reg - hpet_base_reg;
    assign lapic_off = base_reg - lapic_base_reg;
    assign io_hit    = io_off < ioapic_len_reg;
    assign hpet_hit  = hpet_off < hpet_len_reg;
    assign lapic_hit = lapic_en_reg && (lapic_off < lapic_len_reg);

    always_comb
    begin
        case (op_reg)
            OP_REGISTER: scan_hit = !((base_reg >= end_rd) || (end_reg <= start_rd));
            OP_RELOCATE: scan_hit = (start_rd == base_reg);
            OP_LOOKUP:   scan_hit = (base_reg >= start_rd) && (base_reg < end_rd);
            default:     scan_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        base_next     = base_reg;
        arg_next      = arg_reg;
        end_next      = end_reg;
        len_next      = len_reg;
        hit_idx_next  = hit_idx_reg;
        rd_idx_next   = rd_idx_reg;
        ev_valid_next = 1'b0;
        ev_idx_next   = ev_idx_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        tgt_next      = tgt_reg;
        slot_next     = slot_reg;
        offset_next   = offset_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        wr_start      = base_reg;
        wr_end        = end_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    base_next  = address;
                    arg_next   = (opcode == OP_RELOCATE) ? new_start : length;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                rd_idx_next = '0;
                tgt_next    = TG_NONE;
                slot_next   = '0;
                offset_next = '0;
                case (op_reg)
                    OP_REGISTER:
                    begin
                        if (count_reg >= CNT_W'(WINDOWS))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                            state_next  = S_IDLE;
                        end
                        else if (arg_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_ZERO;
                            state_next  = S_IDLE;
                        end
                        else if (reg_sum[ADDR_W] || (reg_sum[ADDR_W-1:0] == '0))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OVERFLOW;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            end_next   = reg_sum[ADDR_W-1:0];
                            state_next = S_SCAN;
                        end
                    end
                    OP_RELOCATE:
                    begin
                        state_next = S_SCAN;
                    end
                    OP_LOOKUP:
                    begin
                        // fixed windows take priority over the table
                        if (io_hit || hpet_hit || lapic_hit)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            state_next  = S_IDLE;
                            if (io_hit)
                            begin
                                tgt_next    = TG_IOAPIC;
                                offset_next = io_off;
                            end
                            else if (hpet_hit)
                            begin
                                tgt_next    = TG_HPET;
                                offset_next = hpet_off;
                            end
                            else
                            begin
                                tgt_next    = TG_LAPIC;
                                offset_next = lapic_off;
                            end
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISS;
                        state_next  = S_IDLE;
                    end
                endcase
            end

            S_SCAN:
            begin
                // ram data on this cycle belongs to ev_idx_reg
                if (ev_valid_reg && scan_hit)
                begin
                    case (op_reg)
                        OP_REGISTER:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OVERLAP;
                            state_next  = S_IDLE;
                        end
                        OP_RELOCATE:
                        begin
                            len_next     = end_rd - start_rd;
                            hit_idx_next = ev_idx_reg;
                            state_next   = S_RELOC;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            tgt_next    = TG_TABLE;
                            slot_next   = 4'(ev_idx_reg);
                            offset_next = base_reg - start_rd;
                            state_next  = S_IDLE;
                        end
                    endcase
                end
                else if (rd_idx_reg < count_reg)
                begin
                    ev_valid_next = 1'b1;
                    ev_idx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                else if (!ev_valid_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_REGISTER:
                        begin
                            wr_en       = 1'b1;
                            status_next = ST_OK;
                            slot_next   = 4'(count_reg);
                            count_next  = count_reg + CNT_W'(1);
                        end
                        OP_RELOCATE: status_next = ST_NOTFOUND;
                        default:     status_next = ST_MISS;
                    endcase
                end
            end

            S_RELOC:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (rel_sum[ADDR_W] || (rel_sum[ADDR_W-1:0] == '0))
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = hit_idx_reg;
                    wr_start    = arg_reg;
                    wr_end      = rel_sum[ADDR_W-1:0];
                    status_next = ST_OK;
                    slot_next   = 4'(hit_idx_reg);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ev_valid_reg <= 1'b0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            status_reg   <= '0;
            tgt_reg      <= '0;
            slot_reg     <= '0;
            offset_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ev_valid_reg <= ev_valid_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            tgt_reg      <= tgt_next;
            slot_reg     <= slot_next;
            offset_reg   <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        base_reg    <= base_next;
        arg_reg     <= arg_next;
        end_reg     <= end_next;
        len_reg     <= len_next;
        hit_idx_reg <= hit_idx_next;
        rd_idx_reg  <= rd_idx_next;
        ev_idx_reg  <= ev_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ioapic_base_reg <= IOAPIC_BASE_RST;
            ioapic_len_reg  <= IOAPIC_SIZE_RST;
            hpet_base_reg   <= HPET_BASE_RST;
            hpet_len_reg    <= HPET_SIZE_RST;
            lapic_base_reg  <= LAPIC_BASE_RST;
            lapic_len_reg   <= LAPIC_SIZE_RST;
            lapic_en_reg    <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IOAPIC_BASE:  ioapic_base_reg <= cfg_data;
                CFG_IOAPIC_SIZE:  ioapic_len_reg  <= cfg_data;
                CFG_HPET_BASE:    hpet_base_reg   <= cfg_data;
                CFG_HPET_SIZE:    hpet_len_reg    <= cfg_data;
                CFG_LAPIC_BASE:   lapic_base_reg  <= cfg_data;
                CFG_LAPIC_SIZE:   lapic_len_reg   <= cfg_data;
                CFG_LAPIC_ENABLE: lapic_en_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign target     = tgt_reg;
    assign slot_index = slot_reg;
    assign offset     = offset_reg;

    // a result beat only follows a command in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE))
        else $error("result beat without a command in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOWS))
        else $error("window count beyond table depth");

    // the count only moves on a successful register beat
    a_count_moves_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (done_reg && (status_reg == ST_OK)
            && (tgt_reg == TG_NONE)))
        else $error("window count changed outside a register result");

    // entries under evaluation are always registered ones
    a_eval_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && (state_reg == S_SCAN)) |-> (CNT_W'(ev_idx_reg) < count_reg))
        else $error("scan evaluating an unregistered entry");

    a_ram_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (done_reg && (state_reg == S_IDLE)))
        else $error("table write not closing a command");

endmodule
